// ===== rtl/core/natt_pkg.sv =====
// Package for the NAPT translation table: command, status, protocol and flag codes.
// Used by all modules in rtl/core.
`default_nettype none
package natt_pkg;
    localparam logic [2:0] CMD_OUT  = 3'd0;
    localparam logic [2:0] CMD_IN   = 3'd1;
    localparam logic [2:0] CMD_FADD = 3'd2;
    localparam logic [2:0] CMD_FDEL = 3'd3;
    localparam logic [2:0] CMD_AGE  = 3'd4;
    localparam logic [2:0] CMD_FIND = 3'd5;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_PASS    = 3'd1;
    localparam logic [2:0] ST_DISABLE = 3'd2;
    localparam logic [2:0] ST_NOMATCH = 3'd3;
    localparam logic [2:0] ST_BADPROT = 3'd4;
    localparam logic [2:0] ST_FULL    = 3'd5;
    localparam logic [2:0] ST_DUP     = 3'd6;

    localparam logic [7:0] P_TCP  = 8'd6;
    localparam logic [7:0] P_UDP  = 8'd17;
    localparam logic [7:0] P_ICMP = 8'd1;

    localparam logic [10:0] TCP_AGE_LIMIT = 11'd360;
    localparam logic [15:0] PORT_LOW  = 16'd1024;
    localparam logic [15:0] PORT_HIGH = 16'hFFFF;

    localparam int FL_FWD = 0;
    localparam int FL_RST = 1;
    localparam int FL_SYN = 2;
    localparam int FL_FIN_IN = 3;
    localparam int FL_FIN_OUT = 4;

    typedef struct packed {
        logic [7:0]  proto;
        logic [31:0] priv_addr;
        logic [15:0] priv_port;
        logic [31:0] remote_addr;
        logic [15:0] remote_port;
        logic [31:0] pub_addr;
        logic [15:0] pub_port;
        logic [10:0] age;
        logic [4:0]  flags;
    } entry_t;

    typedef struct packed {
        logic priv_hit;
        logic pub_hit;
    } match_t;
endpackage
`default_nettype wire

// ===== rtl/core/natt_match.sv =====
// Shared key compare unit: tests one stored entry against the private and public keys.
// Depends on natt_pkg.
`default_nettype none
module natt_match
    import natt_pkg::*;
(
    input  wire logic        ent_valid,
    input  wire entry_t      ent,
    input  wire logic [7:0]  key_proto,
    input  wire logic [31:0] key_addr,
    input  wire logic [15:0] key_priv_port,
    input  wire logic [15:0] key_pub_port,
    output match_t           hit
);
    logic proto_eq;
    assign proto_eq = ent_valid && (ent.proto == key_proto);
    assign hit.priv_hit = proto_eq && (ent.priv_addr == key_addr)
                          && (ent.priv_port == key_priv_port);
    assign hit.pub_hit = proto_eq && (ent.pub_port == key_pub_port);
endmodule
`default_nettype wire

// ===== rtl/core/nat_translation_table.sv =====
// NAPT translation table top level: sequencer, entry memory, valid bits, output register.
// Latency: every command scans the table, one entry a cycle from the entry memory (one read port, one write port);
// after the scan the sequencer passes S_WAIT, S_DECIDE and S_DONE, and m_tvalid rises once the output is free.
// A new transaction is taken only in S_IDLE with no write pending; hold longer while a result waits on m_tready.
// aresetn (synchronous, active low) clears valid bits, sequencer and config registers;
// entry memory is not cleared.
`default_nettype none
module nat_translation_table
    import natt_pkg::*;
#(
    parameter int ENTRIES = 64
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         cfg_we,
    input  wire logic [0:0]   cfg_index,
    input  wire logic [31:0]  cfg_wdata,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // cmd, proto, source address, source port, destination address, destination port,
    // ext_addr, ext_port, fresh_port, fresh_port_free, tcp_flags, link address (+1 unused bit)
    input  wire logic [207:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // status, new_addr, new_port, found, removed_count (+5 zero bits)
    output logic [63:0]       m_tdata
);
    localparam int IW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);

    typedef enum logic [2:0] {S_IDLE, S_SCAN, S_WAIT, S_DECIDE, S_WRITE, S_DONE} state_t;

    logic        nat_enable_reg;
    logic [31:0] public_addr_reg;

    state_t      state_reg;
    logic [206:0] in_reg;
    logic [CW-1:0] scan_reg;
    logic [IW-1:0] rd_idx_reg;
    logic        rd_live_reg;
    logic        priv_found_reg, pub_found_reg, free_found_reg;
    logic [IW-1:0] priv_idx_reg, pub_idx_reg, free_idx_reg;
    entry_t      priv_ent_reg, pub_ent_reg;
    logic [6:0]  removed_reg;
    logic [ENTRIES-1:0] valid_reg;
    logic        wr_en_reg;
    logic [IW-1:0] wr_idx_reg;
    entry_t      wr_ent_reg;
    logic [2:0]  status_reg;
    logic [31:0] naddr_reg;
    logic [15:0] nport_reg;
    logic        found_reg;

    entry_t mem [ENTRIES];
    entry_t rd_ent;

    logic [2:0]  f_cmd;
    logic [7:0]  f_proto;
    logic [31:0] f_saddr, f_daddr, f_xaddr, f_laddr;
    logic [15:0] f_sport, f_dport, f_xport, f_fport;
    logic        f_ffree;
    logic [2:0]  f_tfl;

    assign f_cmd   = in_reg[2:0];
    assign f_proto = in_reg[10:3];
    assign f_saddr = in_reg[42:11];
    assign f_sport = in_reg[58:43];
    assign f_daddr = in_reg[90:59];
    assign f_dport = in_reg[106:91];
    assign f_xaddr = in_reg[138:107];
    assign f_xport = in_reg[154:139];
    assign f_fport = in_reg[170:155];
    assign f_ffree = in_reg[171];
    assign f_tfl   = in_reg[174:172];
    assign f_laddr = in_reg[206:175];

    logic [31:0] key_addr;
    logic [15:0] key_priv_port, key_pub_port;
    match_t hit;

    always_comb begin
        key_addr = f_saddr;
        key_priv_port = f_sport;
        key_pub_port = f_xport;
        if (f_cmd == CMD_IN) begin
            key_pub_port = f_dport;
        end else if (f_cmd == CMD_OUT) begin
            key_pub_port = f_fport;
        end
    end

    natt_match u_match (
        .ent_valid    (rd_live_reg && valid_reg[rd_idx_reg]),
        .ent          (rd_ent),
        .key_proto    (f_proto),
        .key_addr     (key_addr),
        .key_priv_port(key_priv_port),
        .key_pub_port (key_pub_port),
        .hit          (hit)
    );

    always_ff @(posedge aclk) begin
        rd_ent <= mem[scan_reg[IW-1:0]];
        if (wr_en_reg) begin
            mem[wr_idx_reg] <= wr_ent_reg;
        end
    end

    // aging decision for the entry being read
    logic age_keep_tcp, age_del;
    logic [10:0] age_new;
    entry_t aged_ent;
    always_comb begin
        age_del = 1'b0;
        age_keep_tcp = 1'b0;
        age_new = rd_ent.age + 11'd1;
        if (rd_ent.proto == P_TCP) begin
            if (rd_ent.flags[FL_FWD]) begin
                age_keep_tcp = 1'b1;
            end else if (rd_ent.age == 11'd0 || rd_ent.age > TCP_AGE_LIMIT) begin
                age_del = 1'b1;
            end else if (rd_ent.flags[FL_RST]
                         || (rd_ent.flags[FL_FIN_IN] && rd_ent.flags[FL_FIN_OUT])) begin
                age_new = 11'd0;
            end
        end else if (rd_ent.proto == P_UDP && rd_ent.flags[FL_FWD]) begin
            age_keep_tcp = 1'b1;
        end else if (rd_ent.age > 11'd1) begin
            age_del = 1'b1;
        end
        aged_ent = rd_ent;
        aged_ent.age = age_new;
    end

    logic dis, bad_proto;
    assign dis = !nat_enable_reg || (f_laddr != public_addr_reg);
    assign bad_proto = (f_proto != P_TCP) && (f_proto != P_UDP);

    function automatic entry_t sniff(entry_t e, logic [7:0] p, logic [2:0] fl, logic inb);
        entry_t r;
        r = e;
        if (p == P_TCP) begin
            if (fl[1]) r.flags[FL_SYN] = 1'b1;
            if (fl[2]) r.flags[FL_RST] = 1'b1;
            if (fl[0]) begin
                if (inb) r.flags[FL_FIN_IN] = 1'b1;
                else r.flags[FL_FIN_OUT] = 1'b1;
            end
        end else if (p == P_UDP) begin
            r.age = 11'd1;
        end
        return r;
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nat_enable_reg <= 1'b0;
            public_addr_reg <= '0;
            state_reg <= S_IDLE;
            valid_reg <= '0;
            wr_en_reg <= 1'b0;
            rd_live_reg <= 1'b0;
            m_tvalid <= 1'b0;
        end else begin
            if (cfg_we) begin
                if (cfg_index == 1'b0) nat_enable_reg <= cfg_wdata[0];
                else public_addr_reg <= cfg_wdata;
            end
            wr_en_reg <= 1'b0;
            if (m_tvalid && m_tready) m_tvalid <= 1'b0;
            case (state_reg)
                S_IDLE: begin
                    if (s_tvalid && s_tready) begin
                        in_reg <= s_tdata[206:0];
                        scan_reg <= '0;
                        priv_found_reg <= 1'b0;
                        pub_found_reg <= 1'b0;
                        free_found_reg <= 1'b0;
                        removed_reg <= '0;
                        rd_live_reg <= 1'b0;
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    // issue read of scan_reg; evaluate entry read last cycle
                    rd_idx_reg <= scan_reg[IW-1:0];
                    rd_live_reg <= 1'b1;
                    if (scan_reg == CW'(ENTRIES - 1)) state_reg <= S_WAIT;
                    else scan_reg <= scan_reg + CW'(1);
                    if (rd_live_reg) begin
                        if (hit.priv_hit && !priv_found_reg) begin
                            priv_found_reg <= 1'b1;
                            priv_idx_reg <= rd_idx_reg;
                            priv_ent_reg <= rd_ent;
                        end
                        if (hit.pub_hit && !pub_found_reg) begin
                            pub_found_reg <= 1'b1;
                            pub_idx_reg <= rd_idx_reg;
                            pub_ent_reg <= rd_ent;
                        end
                        if (!valid_reg[rd_idx_reg] && !free_found_reg) begin
                            free_found_reg <= 1'b1;
                            free_idx_reg <= rd_idx_reg;
                        end
                        if (f_cmd == CMD_AGE && valid_reg[rd_idx_reg] && !age_keep_tcp) begin
                            if (age_del) begin
                                valid_reg[rd_idx_reg] <= 1'b0;
                                if (removed_reg != 7'd127) removed_reg <= removed_reg + 7'd1;
                            end else begin
                                wr_en_reg <= 1'b1;
                                wr_idx_reg <= rd_idx_reg;
                                wr_ent_reg <= aged_ent;
                            end
                        end
                    end
                end
                S_WAIT: begin
                    // last entry is read this cycle; evaluate it
                    rd_live_reg <= 1'b0;
                    if (rd_live_reg) begin
                        if (hit.priv_hit && !priv_found_reg) begin
                            priv_found_reg <= 1'b1;
                            priv_idx_reg <= rd_idx_reg;
                            priv_ent_reg <= rd_ent;
                        end
                        if (hit.pub_hit && !pub_found_reg) begin
                            pub_found_reg <= 1'b1;
                            pub_idx_reg <= rd_idx_reg;
                            pub_ent_reg <= rd_ent;
                        end
                        if (!valid_reg[rd_idx_reg] && !free_found_reg) begin
                            free_found_reg <= 1'b1;
                            free_idx_reg <= rd_idx_reg;
                        end
                        if (f_cmd == CMD_AGE && valid_reg[rd_idx_reg] && !age_keep_tcp) begin
                            if (age_del) begin
                                valid_reg[rd_idx_reg] <= 1'b0;
                                if (removed_reg != 7'd127) removed_reg <= removed_reg + 7'd1;
                            end else begin
                                wr_en_reg <= 1'b1;
                                wr_idx_reg <= rd_idx_reg;
                                wr_ent_reg <= aged_ent;
                            end
                        end
                    end
                    state_reg <= S_DECIDE;
                end
                S_DECIDE: begin
                    status_reg <= ST_OK;
                    naddr_reg <= '0;
                    nport_reg <= '0;
                    found_reg <= 1'b0;
                    state_reg <= S_DONE;
                    case (f_cmd)
                        CMD_OUT, CMD_IN: begin
                            if (dis) begin
                                status_reg <= ST_DISABLE;
                            end else if (f_proto == P_ICMP) begin
                                status_reg <= ST_PASS;
                                naddr_reg <= (f_cmd == CMD_IN) ? f_daddr : f_saddr;
                                nport_reg <= (f_cmd == CMD_IN) ? f_dport : f_sport;
                            end else if (bad_proto) begin
                                status_reg <= ST_BADPROT;
                            end else if (f_cmd == CMD_IN) begin
                                if (!pub_found_reg) begin
                                    status_reg <= ST_NOMATCH;
                                end else begin
                                    naddr_reg <= pub_ent_reg.priv_addr;
                                    nport_reg <= pub_ent_reg.priv_port;
                                    wr_en_reg <= 1'b1;
                                    wr_idx_reg <= pub_idx_reg;
                                    wr_ent_reg <= sniff(pub_ent_reg, f_proto, f_tfl, 1'b1);
                                end
                            end else if (priv_found_reg) begin
                                naddr_reg <= priv_ent_reg.pub_addr;
                                nport_reg <= priv_ent_reg.pub_port;
                                wr_en_reg <= 1'b1;
                                wr_idx_reg <= priv_idx_reg;
                                wr_ent_reg <= sniff(priv_ent_reg, f_proto, f_tfl, 1'b0);
                            end else if (!f_ffree || f_fport < PORT_LOW
                                         || f_fport == PORT_HIGH) begin
                                status_reg <= ST_FULL;
                            end else if (pub_found_reg) begin
                                status_reg <= ST_DUP;
                            end else if (!free_found_reg) begin
                                status_reg <= ST_FULL;
                            end else begin
                                naddr_reg <= public_addr_reg;
                                nport_reg <= f_fport;
                                valid_reg[free_idx_reg] <= 1'b1;
                                wr_en_reg <= 1'b1;
                                wr_idx_reg <= free_idx_reg;
                                wr_ent_reg <= sniff('{proto: f_proto, priv_addr: f_saddr,
                                    priv_port: f_sport, remote_addr: f_daddr,
                                    remote_port: f_dport, pub_addr: public_addr_reg,
                                    pub_port: f_fport, age: 11'd1, flags: 5'd0},
                                    f_proto, f_tfl, 1'b0);
                            end
                        end
                        CMD_FADD: begin
                            if (priv_found_reg || pub_found_reg) begin
                                status_reg <= ST_DUP;
                            end else if (!free_found_reg) begin
                                status_reg <= ST_FULL;
                            end else begin
                                naddr_reg <= f_xaddr;
                                nport_reg <= f_xport;
                                valid_reg[free_idx_reg] <= 1'b1;
                                wr_en_reg <= 1'b1;
                                wr_idx_reg <= free_idx_reg;
                                wr_ent_reg <= '{proto: f_proto, priv_addr: f_saddr,
                                    priv_port: f_sport, remote_addr: 32'd0,
                                    remote_port: 16'd0, pub_addr: f_xaddr,
                                    pub_port: f_xport, age: 11'd1, flags: 5'(1 << FL_FWD)};
                            end
                        end
                        CMD_FDEL: begin
                            if (!pub_found_reg) status_reg <= ST_NOMATCH;
                            else valid_reg[pub_idx_reg] <= 1'b0;
                        end
                        CMD_AGE: begin
                        end
                        CMD_FIND: begin
                            found_reg <= (f_xport != 16'd0) ? pub_found_reg : priv_found_reg;
                        end
                        default: begin
                            status_reg <= ST_PASS;
                        end
                    endcase
                end
                S_WRITE: begin
                    state_reg <= S_DONE;
                end
                S_DONE: begin
                    if (!m_tvalid) begin
                        m_tvalid <= 1'b1;
                        m_tdata <= {5'd0, (f_cmd == CMD_AGE) ? removed_reg : 7'd0,
                                    found_reg, nport_reg, naddr_reg, status_reg};
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE) && !wr_en_reg;

`ifndef SYNTHESIS
    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> state_reg == S_IDLE) else $error("ready outside idle");
    a_one_txn: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready) else $error("second transaction accepted");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> $stable(m_tdata)) else $error("output changed while stalled");
`endif
endmodule
`default_nettype wire
